[hw/rtl/sorted_table_first_match_search_assert.svh]
// assertion macros for the sorted table search block
// build with NO_ASSERTIONS defined to drop every check
`ifndef SORTED_TABLE_FIRST_MATCH_SEARCH_ASSERT_SVH
`define SORTED_TABLE_FIRST_MATCH_SEARCH_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, sampled on clk, off during reset
`define STS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define STS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define STS_ASSERT_IMP(label, ante, cons, msg)
`define STS_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

[hw/rtl/sts_pkg.sv]
package sts_pkg;

	localparam int KEY_W   = 64;
	localparam int SLOT_W  = 10;
	localparam int POS_W   = 10;
	localparam int COUNT_W = 11;

	// operation codes
	localparam logic FUNC_LOAD   = 1'b0;
	localparam logic FUNC_SEARCH = 1'b1;

	typedef struct packed {
		logic              func;
		logic [KEY_W-1:0]  key;
		logic [SLOT_W-1:0] slot;
	} in_item_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] first_position;
	} out_item_t;

endpackage

[hw/rtl/sorted_table_first_match_search.sv]
// channel  | direction | handshake          | payload
// ---------+-----------+--------------------+--------------------------------
// in       | in        | in_valid/in_stall  | in_item_t: func, key, slot
// out      | out       | out_valid/out_stall| out_item_t: found, first_position
// cfg      | in        | cfg_valid/cfg_ready| entry_count, 11 bits
//
// at TABLE_DEPTH 1024 or more a load is written on its accept edge; below
// that the slot is first reduced modulo the depth, one conditional subtract
// per cycle; a search halves its range at most ceil(log2(n+1)) times, n being
// entry_count saturated at the depth, and closes with an equality read if the
// bound is below n; one synchronous key memory read per cycle feeds each midpoint
// reset clears control and entry_count only; the key memory is not cleared
// a result that waits under out_stall holds the search in its last cycle; the
// next item is taken while that result is still waiting
module sorted_table_first_match_search
	import sts_pkg::*;
#(
	parameter int TABLE_DEPTH = 1024,
	parameter int KEY_BITS    = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  in_item_t           in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output out_item_t          out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [COUNT_W-1:0] cfg_data
);

`include "sorted_table_first_match_search_assert.svh"

	localparam int ADDR_W = $clog2(TABLE_DEPTH);
	// wide enough to hold TABLE_DEPTH itself
	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	// common width for saturating the count register
	localparam int SAT_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
	// conditional subtracts needed to reduce a slot below the depth
	localparam int SLOT_SPAN = 1 << SLOT_W;
	localparam int MOD_STEPS = (TABLE_DEPTH >= SLOT_SPAN) ? 0 :
		$clog2(SLOT_SPAN / TABLE_DEPTH + 1);
	localparam int STEP_W = $clog2(SLOT_W + 1);
	localparam int MW     = SLOT_W + SLOT_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MOD  = 2'd1;
	localparam logic [1:0] ST_SRCH = 2'd2;

	logic [1:0]          state_q;
	logic [COUNT_W-1:0]  entry_count_q;

	// key memory and its registered read port
	logic [KEY_BITS-1:0] key_mem_q [TABLE_DEPTH];
	logic [KEY_BITS-1:0] rd_data_q;
	logic                rd_en;
	logic [ADDR_W-1:0]   rd_addr;
	logic                wr_en;
	logic [ADDR_W-1:0]   wr_addr;
	logic [KEY_BITS-1:0] wr_data;

	// search registers
	logic [KEY_BITS-1:0] key_q;
	logic [CNT_W-1:0]    lo_q;
	logic [CNT_W-1:0]    hi_q;
	logic [CNT_W-1:0]    n_q;
	logic [ADDR_W-1:0]   addr_q;
	logic                have_q;   // rd_data_q holds the entry at addr_q
	logic                final_q;  // that read was the closing equality check

	// slot reduction registers
	logic [SLOT_W-1:0]   r_q;
	logic [STEP_W-1:0]   step_q;

	logic                out_valid_q;
	out_item_t           out_data_q;

	logic                in_xfer;
	logic [KEY_BITS-1:0] key_in;
	logic [SAT_W-1:0]    cnt_ext;
	logic [CNT_W-1:0]    n_sat;

	logic [CNT_W-1:0]    lo_n;
	logic [CNT_W-1:0]    hi_n;
	logic [CNT_W-1:0]    mid_n;
	logic                lt;
	logic                res_now;
	logic                res_found;
	logic                rd_want;
	logic                final_n;
	logic                out_free;
	logic                advance;

	logic [MW-1:0]       sub_val;
	logic [SLOT_W-1:0]   r_n;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign key_in    = in_data.key[KEY_BITS-1:0];
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// entry_count above the depth searches the whole table
	assign cnt_ext = SAT_W'(entry_count_q);
	assign n_sat   = (cnt_ext > SAT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : CNT_W'(cnt_ext);

	// one conditional subtract of depth << step
	assign sub_val = MW'(TABLE_DEPTH) << step_q;
	assign r_n = (MW'(r_q) >= sub_val) ? (r_q - sub_val[SLOT_W-1:0]) : r_q;

	// one lower-bound step: fold in the entry just read, pick the next read
	assign lt = (rd_data_q < key_q);

	always_comb begin
		lo_n      = lo_q;
		hi_n      = hi_q;
		res_now   = 1'b0;
		res_found = 1'b0;
		rd_want   = 1'b0;
		final_n   = 1'b0;
		if (have_q && !final_q) begin
			if (lt) begin
				lo_n = CNT_W'(addr_q) + CNT_W'(1);
			end else begin
				hi_n = CNT_W'(addr_q);
			end
		end
		mid_n   = lo_n + ((hi_n - lo_n) >> 1);
		rd_addr = ADDR_W'(mid_n);
		if (have_q && final_q) begin
			// closing check on the slot the search ended on
			res_now   = 1'b1;
			res_found = (rd_data_q == key_q);
		end else if (lo_n < hi_n) begin
			rd_want = 1'b1;
		end else if (lo_n < n_q) begin
			rd_want = 1'b1;
			rd_addr = ADDR_W'(lo_n);
			final_n = 1'b1;
		end else begin
			// ran off the end of the used range
			res_now = 1'b1;
		end
	end

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = (state_q == ST_SRCH) && (!res_now || out_free);
	assign rd_en    = advance && rd_want;

	// loads write on the accept edge, or after slot reduction
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = ADDR_W'(in_data.slot);
		wr_data = key_in;
		if (state_q == ST_MOD) begin
			wr_en   = (step_q == '0);
			wr_addr = ADDR_W'(r_n);
			wr_data = key_q;
		end else if (in_xfer && in_data.func == FUNC_LOAD && MOD_STEPS == 0) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= key_mem_q[rd_addr];
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			entry_count_q <= cfg_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			have_q  <= 1'b0;
			final_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (in_data.func == FUNC_SEARCH) begin
							have_q  <= 1'b0;
							final_q <= 1'b0;
							state_q <= ST_SRCH;
						end else if (MOD_STEPS != 0) begin
							state_q <= ST_MOD;
						end
					end
				end
				ST_MOD: begin
					if (step_q == '0) begin
						state_q <= ST_IDLE;
					end
				end
				ST_SRCH: begin
					if (advance) begin
						have_q  <= rd_want;
						final_q <= final_n;
						if (res_now) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// search and reduction datapath
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			key_q  <= key_in;
			lo_q   <= '0;
			hi_q   <= n_sat;
			n_q    <= n_sat;
			r_q    <= in_data.slot;
			step_q <= STEP_W'(MOD_STEPS - 1);
		end else if (state_q == ST_MOD) begin
			r_q    <= r_n;
			step_q <= step_q - STEP_W'(1);
		end else if (advance) begin
			lo_q   <= lo_n;
			hi_q   <= hi_n;
			addr_q <= rd_addr;
		end
	end

	// result register, parts the search from the downstream stall
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (advance && res_now) begin
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_now) begin
			out_data_q.found          <= res_found;
			out_data_q.first_position <= res_found ? POS_W'(lo_q) : '0;
		end
	end

	// every read stays inside the searched range
	`STS_ASSERT_IMP(a_rd_in_range, rd_en, (CNT_W'(rd_addr) < n_q), "read beyond entry count")
	// bounds never cross
	`STS_ASSERT_IMP(a_bounds, (state_q == ST_SRCH), ((lo_q <= hi_q) && (hi_q <= n_q)),
		"search bounds out of order")
	// reduced slot lands inside the table
	`STS_ASSERT_IMP(a_mod_range, (wr_en && (state_q == ST_MOD)),
		(MW'(r_n) < MW'(TABLE_DEPTH)), "load slot not reduced below depth")
	// a result appears only out of the search loop
	`STS_ASSERT_NXT(a_res_src, (!out_valid_q || !out_stall) && !(advance && res_now),
		!out_valid_q, "result without a finished search")

endmodule

[bench/sorted_table_first_match_search_test.sv]
module sorted_table_first_match_search_test;
	import sts_pkg::*;

	localparam int TABLE_DEPTH   = 1024;
	localparam int CLK_HALF      = 4;
	localparam int SETTLE_CYCLES = 24;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int HOLD_CYCLES   = 500;

	// idling percentages per phase
	localparam int PCT_OFF  = 0;
	localparam int PCT_HIGH = 86;
	localparam int PCT_MID  = 34;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	in_item_t           in_data = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	out_item_t          out_data;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [COUNT_W-1:0] cfg_data = '0;

	// items still to be offered, and search answers still to come
	in_item_t  table_ops_q[$];
	out_item_t search_answers_q[$];

	// predictor state: key table as the block should hold it, and the entry count
	logic [KEY_W-1:0] key_mirror [TABLE_DEPTH];
	int unsigned      active_entries = 0;

	// keys as planned at queueing time, used to aim searches at stored keys
	logic [KEY_W-1:0] planned_keys [TABLE_DEPTH];

	int          send_idle_pct = PCT_OFF;
	int          recv_stall_pct = PCT_OFF;
	int          failures = 0;
	int unsigned cycle_count = 0;

	// long receiver hold-off, requested once from the main sequence
	logic        hold_request = 1'b0;
	logic        hold_used = 1'b0;
	int unsigned hold_left = 0;

	sorted_table_first_match_search #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.KEY_BITS(KEY_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// lower-bound search over the entries in use, count saturated at the depth
	function automatic out_item_t lower_bound_lookup(input logic [KEY_W-1:0] key);
		int unsigned n;
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		out_item_t   res;
		n = (active_entries > TABLE_DEPTH) ? TABLE_DEPTH : active_entries;
		lo = 0;
		hi = n;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (key_mirror[mid[SLOT_W-1:0]] < key) begin
				lo = mid + 1;
			end else begin
				hi = mid;
			end
		end
		res = '0;
		if (lo < n && key_mirror[lo[SLOT_W-1:0]] == key) begin
			res.found = 1'b1;
			res.first_position = lo[POS_W-1:0];
		end
		return res;
	endfunction

	function automatic logic [KEY_W-1:0] rand_key();
		return {$urandom, $urandom};
	endfunction

	// driver: offer the next pending item, hold it until the transfer happens
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			// predict at the transfer, in the order the block takes items
			if (in_valid && !in_stall) begin
				if (in_data.func == FUNC_LOAD) begin
					key_mirror[in_data.slot] = in_data.key;
				end else begin
					search_answers_q.push_back(lower_bound_lookup(in_data.key));
				end
			end
			if (!in_valid || !in_stall) begin
				if (table_ops_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_data <= table_ops_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// hold-off counter, runs in its own process
	always @(posedge clk) begin
		if (hold_request && !hold_used) begin
			hold_left <= HOLD_CYCLES;
			hold_used <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// receiver stall: random per phase, forced high during the hold-off
	always @(posedge clk) begin
		out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
	end

	// monitor: every result transfer is checked against the oldest answer
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (search_answers_q.size() == 0) begin
				$error("result with no search pending: found %0d first_position %0d",
					out_data.found, out_data.first_position);
				failures++;
			end else begin
				want = search_answers_q.pop_front();
				if (out_data.found !== want.found) begin
					$error("found: expected %0d, actual %0d", want.found, out_data.found);
					failures++;
				end
				if (out_data.first_position !== want.first_position) begin
					$error("first_position: expected %0d, actual %0d",
						want.first_position, out_data.first_position);
					failures++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic queue_op(input logic func, input logic [KEY_W-1:0] key,
		input logic [SLOT_W-1:0] slot);
		in_item_t item;
		item.func = func;
		item.key = key;
		item.slot = slot;
		if (func == FUNC_LOAD) begin
			planned_keys[slot] = key;
		end
		table_ops_q.push_back(item);
	endtask

	// wait until every item went in and every answer came out, then let
	// a trailing load finish inside the block
	task automatic settle();
		while (table_ops_q.size() != 0 || in_valid || search_answers_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// only called while the block is idle
	task automatic write_entry_count(input logic [COUNT_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		active_entries = 32'(value);
	endtask

	// one phase: set the count, optionally request the receiver hold-off and reload
	// a sorted table, then searches aimed mostly at stored keys, with a little noise
	task automatic run_phase(input int unsigned count, input int send_pct, input int recv_pct,
		input int searches, input bit reload, input bit squeeze);
		int unsigned      used;
		logic [KEY_W-1:0] step_max;
		logic [KEY_W-1:0] run_key;
		logic [KEY_W-1:0] key;
		int unsigned      pick;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		write_entry_count(count[COUNT_W-1:0]);
		used = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
		if (squeeze) begin
			@(posedge clk);
			hold_request <= 1'b1;
		end
		if (reload && used != 0) begin
			// ascending keys spread over the whole range, with runs of duplicates
			step_max = (~64'd0) / (used + 1);
			run_key = rand_key() % step_max;
			for (int i = 0; i < used; i++) begin
				if (i != 0 && $urandom_range(3) != 0) begin
					run_key = run_key + 1 + rand_key() % step_max;
				end
				queue_op(FUNC_LOAD, run_key, i[SLOT_W-1:0]);
			end
		end
		for (int i = 0; i < searches; i++) begin
			pick = $urandom_range(99);
			key = rand_key();
			if (used != 0 && pick < 55) begin
				key = planned_keys[SLOT_W'($urandom_range(used - 1))];
			end else if (used != 0 && pick < 70) begin
				key = planned_keys[SLOT_W'($urandom_range(used - 1))];
				key = $urandom_range(1) ? key + 1 : key - 1;
			end else if (pick >= 85 && pick < 90) begin
				key = '0;
			end else if (pick >= 90 && pick < 95) begin
				key = '1;
			end
			if (pick >= 95) begin
				// stray load, may break the order of the table
				queue_op(FUNC_LOAD, rand_key(), SLOT_W'($urandom_range(TABLE_DEPTH - 1)));
			end else begin
				queue_op(FUNC_SEARCH, key, SLOT_W'($urandom_range(TABLE_DEPTH - 1)));
			end
		end
		settle();
	endtask

	// entry count at or past the depth: only the leftmost and rightmost search
	// paths get loaded, so the searches use the all-zero and all-one keys only
	task automatic run_full_count(input int unsigned count, input int send_pct,
		input int recv_pct, input int searches);
		int unsigned      span;
		logic [KEY_W-1:0] key;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		write_entry_count(count[COUNT_W-1:0]);
		// leftmost path: slot zero and the powers of two
		key = '0;
		if ($urandom_range(1) != 0) begin
			key = rand_key();
		end
		queue_op(FUNC_LOAD, key, '0);
		for (span = 1; span < TABLE_DEPTH; span = span << 1) begin
			queue_op(FUNC_LOAD, rand_key() >> 1, span[SLOT_W-1:0]);
		end
		// rightmost path, every entry below the all-one key except the last
		for (span = 2; span < TABLE_DEPTH / 2; span = span << 1) begin
			queue_op(FUNC_LOAD, rand_key() >> 1, SLOT_W'(TABLE_DEPTH - span));
		end
		key = '1;
		if ($urandom_range(1) != 0) begin
			key = key - 1;
		end
		queue_op(FUNC_LOAD, key, SLOT_W'(TABLE_DEPTH - 1));
		for (int i = 0; i < searches; i++) begin
			key = '0;
			if ($urandom_range(1) != 0) begin
				key = '1;
			end
			queue_op(FUNC_SEARCH, key, SLOT_W'($urandom_range(TABLE_DEPTH - 1)));
		end
		settle();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table: nothing can be found
		write_entry_count('0);
		queue_op(FUNC_SEARCH, '0, '0);
		queue_op(FUNC_SEARCH, '1, '1);
		settle();

		// small sorted table with a run of equal keys and name-like keys
		queue_op(FUNC_LOAD, 64'd0, 10'd0);
		queue_op(FUNC_LOAD, 64'd5, 10'd1);
		queue_op(FUNC_LOAD, 64'd5, 10'd2);
		queue_op(FUNC_LOAD, 64'd5, 10'd3);
		queue_op(FUNC_LOAD, 64'h414C_4641_0000_0000, 10'd4);
		queue_op(FUNC_LOAD, 64'h4245_5441_0000_0000, 10'd5);
		queue_op(FUNC_LOAD, 64'hFFFF_FFFF_FFFF_FFFE, 10'd6);
		queue_op(FUNC_LOAD, 64'hFFFF_FFFF_FFFF_FFFF, 10'd7);
		queue_op(FUNC_LOAD, 64'hFFFF_FFFF_FFFF_FFFF, 10'd1023);
		settle();
		write_entry_count(11'd8);
		queue_op(FUNC_SEARCH, 64'd0, 10'd1023);
		queue_op(FUNC_SEARCH, 64'd5, 10'd0);
		queue_op(FUNC_SEARCH, 64'd3, 10'd0);
		queue_op(FUNC_SEARCH, 64'h414C_4641_0000_0000, 10'd0);
		queue_op(FUNC_SEARCH, 64'h414C_4600_0000_0000, 10'd0);
		queue_op(FUNC_SEARCH, 64'hFFFF_FFFF_FFFF_FFFE, 10'd0);
		queue_op(FUNC_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 10'd0);
		settle();

		// out-of-order table: answer is whatever the search path lands on
		queue_op(FUNC_LOAD, 64'd100, 10'd0);
		queue_op(FUNC_LOAD, 64'd10, 10'd1);
		queue_op(FUNC_LOAD, 64'd50, 10'd2);
		settle();
		write_entry_count(11'd3);
		queue_op(FUNC_SEARCH, 64'd10, 10'd0);
		queue_op(FUNC_SEARCH, 64'd50, 10'd0);
		queue_op(FUNC_SEARCH, 64'd100, 10'd0);
		settle();

		// random phases over the idling patterns and count extremes
		run_phase($urandom_range(40, 1), PCT_OFF, PCT_OFF, 100, 1'b1, 1'b1);
		run_phase($urandom_range(100, 2), PCT_HIGH, PCT_OFF, 100, 1'b1, 1'b0);
		run_full_count(TABLE_DEPTH, PCT_OFF, PCT_HIGH, 60);
		run_full_count(2047, PCT_MID, PCT_MID, 60);
		run_phase(1, PCT_MID, PCT_MID, 50, 1'b0, 1'b0);
		run_phase($urandom_range(300, 41), PCT_OFF, PCT_OFF, 100, 1'b1, 1'b0);
		run_phase(0, PCT_HIGH, PCT_HIGH, 20, 1'b0, 1'b0);
		run_full_count($urandom_range(2046, TABLE_DEPTH + 1), PCT_OFF, PCT_HIGH, 60);

		if (failures == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

[sorted_table_first_match_search.f]
+incdir+hw/rtl
hw/rtl/sts_pkg.sv
hw/rtl/sorted_table_first_match_search.sv
bench/sorted_table_first_match_search_test.sv
